### src/detection_box_decoder_core_assert.svh
// Assertion macros shared by the detection box decoder RTL.
`ifndef DETECTION_BOX_DECODER_CORE_ASSERT_SVH
`define DETECTION_BOX_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Condition must hold at every edge out of reset.
`define DBD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dbd assertion failed");
// Antecedent implies consequent in the same cycle.
`define DBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbd assertion failed");
// Antecedent implies consequent in the next cycle.
`define DBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbd assertion failed");
`else
`define DBD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define DBD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DBD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/dbd_pkg.sv
// Types and constants shared by the detection box decoder modules.
package dbd_pkg;

    localparam int SCORE_W = 16;
    localparam int COORD_W = 15;
    localparam int FRAME_W = 11;
    localparam int NCLS_W  = 8;
    localparam int CLS_W   = 7;
    localparam int CNT_N_W = 11;   // holds a class count up to 2047
    localparam int FRAC_W  = 4;    // Q11.4 fraction bits

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SCORE_W-1:0] THRESHOLD_RST   = 16'd16384;
    localparam logic [FRAME_W-1:0] FRAME_W_RST     = 11'd640;
    localparam logic [FRAME_W-1:0] FRAME_H_RST     = 11'd640;
    localparam logic [NCLS_W-1:0]  CLASS_COUNT_RST = 8'd80;

    // Both clipped sides must exceed 2 pixels in Q11.4.
    localparam logic [COORD_W-1:0] MIN_SIDE = 15'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD   = 2'd0,
        REG_FRAME_W     = 2'd1,
        REG_FRAME_H     = 2'd2,
        REG_CLASS_COUNT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SCORE_W-1:0] threshold;
        logic [FRAME_W-1:0] frame_w;
        logic [FRAME_W-1:0] frame_h;
        logic [NCLS_W-1:0]  class_count;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_geom;

    // Finished box with at least one passing class.
    typedef struct packed {
        t_geom              geom;
        logic [SCORE_W-1:0] score;
        logic [CLS_W-1:0]   class_id;
    } t_box;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [SCORE_W-1:0] confidence;
        logic [CLS_W-1:0]   class_id;
    } t_det;

endpackage

### src/dbd_reduce.sv
// Class score reduction: counts classes, keeps the best passing score, registers the box.
`include "detection_box_decoder_core_assert.svh"

module dbd_reduce #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dbd_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [dbd_pkg::SCORE_W-1:0] i_score,
    input  dbd_pkg::t_geom              i_geom,
    output logic                        o_box_valid,
    input  logic                        i_box_ready,
    output dbd_pkg::t_box               o_box
);
    import dbd_pkg::*;

    localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam logic [CNT_N_W-1:0] MAX_N = CNT_N_W'(MAX_CLASSES);

    logic [CW-1:0]      r_cnt, n_cnt;
    logic [SCORE_W-1:0] r_best, n_best;
    logic [CW-1:0]      r_cls, n_cls;
    logic               r_any, n_any;
    t_geom              r_geom, n_geom;
    logic               r_box_valid;
    t_box               r_box;

    logic [CNT_N_W-1:0] num_n;
    logic [CNT_N_W-1:0] cnt_inc;
    logic               first, pass, last, accept;

    always_comb begin
        num_n = CNT_N_W'(i_cfg.class_count);
        if (num_n == '0) begin
            num_n = CNT_N_W'(1);
        end
        if (num_n > MAX_N) begin
            num_n = MAX_N;
        end
    end

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_box_valid || i_box_ready;
    assign first   = (r_cnt == '0);
    assign cnt_inc = CNT_N_W'(r_cnt) + CNT_N_W'(1);
    assign last    = (cnt_inc >= num_n);

    always_comb begin
        n_geom = first ? i_geom : r_geom;
        n_best = first ? '0 : r_best;
        n_cls  = first ? '0 : r_cls;
        n_any  = first ? 1'b0 : r_any;
        pass   = (i_score > i_cfg.threshold) && (i_score > n_best);
        if (pass) begin
            n_best = i_score;
            n_cls  = r_cnt;
            n_any  = 1'b1;
        end
        n_cnt = last ? '0 : CW'(cnt_inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_any       <= 1'b0;
            r_box_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt <= n_cnt;
                r_any <= n_any;
            end
            if (accept && last && n_any) begin
                r_box_valid <= 1'b1;
            end else if (i_box_ready) begin
                r_box_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_best <= n_best;
            r_cls  <= n_cls;
            r_geom <= n_geom;
        end
        if (accept && last && n_any) begin
            r_box.geom     <= n_geom;
            r_box.score    <= n_best;
            r_box.class_id <= CLS_W'(n_cls);
        end
    end

    assign o_box_valid = r_box_valid;
    assign o_box       = r_box;

    `DBD_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, CNT_N_W'(r_cnt) < MAX_N)
    `DBD_ASSERT_NXT(a_box_hold, i_clk, i_rst_n, r_box_valid && !i_box_ready,
        r_box_valid && $stable(r_box))

endmodule

### src/dbd_clip.sv
// Box clipping to corner form, size filter and output register.
`include "detection_box_decoder_core_assert.svh"

module dbd_clip (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dbd_pkg::t_cfg i_cfg,
    input  logic          i_box_valid,
    output logic          o_box_ready,
    input  dbd_pkg::t_box i_box,
    output logic          o_valid,
    input  logic          i_ready,
    output dbd_pkg::t_det o_det
);
    import dbd_pkg::*;

    function automatic logic [COORD_W-1:0] clip_corner(
        input logic [COORD_W-1:0] centre,
        input logic [COORD_W-1:0] size,
        input logic [FRAME_W-1:0] frame
    );
        logic signed [COORD_W+1:0] twice;
        logic [COORD_W-1:0]        hi;
        logic [COORD_W-1:0]        c;
        twice = $signed({1'b0, centre, 1'b0}) - $signed({2'b00, size});
        hi    = {frame - FRAME_W'(1), {FRAC_W{1'b0}}};
        c     = twice[COORD_W:1];
        if (twice[COORD_W+1] || (twice == '0)) begin
            clip_corner = '0;
        end else begin
            clip_corner = (c > hi) ? hi : c;
        end
    endfunction

    function automatic logic [COORD_W-1:0] cap_side(
        input logic [COORD_W-1:0] size,
        input logic [COORD_W-1:0] corner,
        input logic [FRAME_W-1:0] frame
    );
        logic [COORD_W-1:0] room;
        room     = {frame, {FRAC_W{1'b0}}} - corner;
        cap_side = (size < room) ? size : room;
    endfunction

    logic [FRAME_W-1:0] fw, fh;
    t_det               n_det, r_det;
    logic               r_valid;
    logic               emit, adv;

    assign fw = (i_cfg.frame_w == '0) ? FRAME_W'(1) : i_cfg.frame_w;
    assign fh = (i_cfg.frame_h == '0) ? FRAME_W'(1) : i_cfg.frame_h;

    always_comb begin
        n_det.left       = clip_corner(i_box.geom.cx, i_box.geom.w, fw);
        n_det.top        = clip_corner(i_box.geom.cy, i_box.geom.h, fh);
        n_det.width      = cap_side(i_box.geom.w, n_det.left, fw);
        n_det.height     = cap_side(i_box.geom.h, n_det.top, fh);
        n_det.confidence = i_box.score;
        n_det.class_id   = i_box.class_id;
    end

    assign emit        = (n_det.width > MIN_SIDE) && (n_det.height > MIN_SIDE);
    assign adv         = !r_valid || i_ready;
    assign o_box_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_box_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_det <= n_det;
        end
    end

    assign o_valid = r_valid;
    assign o_det   = r_det;

    `DBD_ASSERT_IMP(a_min_side, i_clk, i_rst_n, r_valid,
        (r_det.width > MIN_SIDE) && (r_det.height > MIN_SIDE))
    `DBD_ASSERT_IMP(a_right_edge, i_clk, i_rst_n, r_valid,
        ({1'b0, r_det.left} + {1'b0, r_det.width}) <= {1'b0, {FRAME_W{1'b1}}, {FRAC_W{1'b0}}})

endmodule

### src/detection_box_decoder_core.sv
// Detection box decoder top level: config registers, stream ports and the two stages.
// Throughput: one class score accepted per clock unless the box register stalls; a new box
// may start the cycle after the last score of the previous one, with no gap between boxes.
// A detection is presented on m_axis once the transaction carrying the last class score of
// its box has passed the box register, then clip and the output register.
// Reset (i_rst_n low, synchronous): clears the class count and both stage valids, and
// loads threshold 0.25, frame 640 x 640 and 80 classes.
module detection_box_decoder_core #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Config write port
    input  logic                            i_cfg_we,
    input  logic [dbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Score stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: class_score[15:0], center_x[30:16], center_y[45:31],
    // size_w[60:46], size_h[75:61], zero fill [79:76]
    input  logic [79:0]                     s_axis_tdata,
    // Detection stream out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0: box_left[14:0], box_top[29:15], box_width[44:30],
    // box_height[59:45], confidence[75:60], class_id[82:76], zero fill [87:83]
    output logic [87:0]                     m_axis_tdata
);
    import dbd_pkg::*;

    t_cfg  r_cfg;
    t_geom in_geom;
    t_box  box;
    t_det  det;
    logic  box_valid, box_ready;

    // Config registers; writes must arrive only while the pipeline is empty (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= THRESHOLD_RST;
            r_cfg.frame_w     <= FRAME_W_RST;
            r_cfg.frame_h     <= FRAME_H_RST;
            r_cfg.class_count <= CLASS_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_THRESHOLD:   r_cfg.threshold   <= i_cfg_data;
                REG_FRAME_W:     r_cfg.frame_w     <= i_cfg_data[FRAME_W-1:0];
                REG_FRAME_H:     r_cfg.frame_h     <= i_cfg_data[FRAME_W-1:0];
                REG_CLASS_COUNT: r_cfg.class_count <= i_cfg_data[NCLS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Unpack the geometry; it is only sampled on the first score of a box.
    assign in_geom.cx = s_axis_tdata[30:16];
    assign in_geom.cy = s_axis_tdata[45:31];
    assign in_geom.w  = s_axis_tdata[60:46];
    assign in_geom.h  = s_axis_tdata[75:61];

    // Stage one: running maximum over the class scores, box register at the end.
    dbd_reduce #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_reduce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_score     (s_axis_tdata[SCORE_W-1:0]),
        .i_geom      (in_geom),
        .o_box_valid (box_valid),
        .i_box_ready (box_ready),
        .o_box       (box)
    );

    // Stage two: clip to the frame, drop boxes too small, hold for the sink.
    dbd_clip u_clip (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_box_valid (box_valid),
        .o_box_ready (box_ready),
        .i_box       (box),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_det       (det)
    );

    assign m_axis_tdata = {5'b0, det.class_id, det.confidence, det.height,
                           det.width, det.top, det.left};

endmodule
